@@ design/udiv64_pkg.sv @@
// ----------------------------------------------------------------------------
// udiv64_pkg
// Shared types and constants for the 64-bit unsigned restoring divider.
// ----------------------------------------------------------------------------
package udiv64_pkg;

    localparam int DATA_BITS     = 64;
    localparam int WORD_BITS_DEF = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } udiv64_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } udiv64_cmd_t;

    typedef struct packed {
        logic last_step;
        logic out_free;
    } udiv64_status_t;

endpackage

@@ design/udiv64_ctrl.sv @@
// ----------------------------------------------------------------------------
// udiv64_ctrl
// Sequencer for the divider: load, one restoring step per cycle, publish.
// ----------------------------------------------------------------------------
module udiv64_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  udiv64_pkg::udiv64_status_t status,
    output udiv64_pkg::udiv64_cmd_t    cmd
);
    import udiv64_pkg::*;

    udiv64_state_t state_reg;
    udiv64_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/udiv64_dpath.sv @@
// ----------------------------------------------------------------------------
// udiv64_dpath
// Restoring shift-and-subtract datapath with the result output register.
// ----------------------------------------------------------------------------
module udiv64_dpath #(
    parameter int WORD_BITS = udiv64_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [udiv64_pkg::DATA_BITS-1:0] dividend,
    input  logic [udiv64_pkg::DATA_BITS-1:0] divisor,
    input  udiv64_pkg::udiv64_cmd_t        cmd,
    output udiv64_pkg::udiv64_status_t     status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [udiv64_pkg::DATA_BITS-1:0] quotient
);
    import udiv64_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] num_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] den_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 den_zero_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DATA_BITS-1:0] quotient_reg;

    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;

    assign trial = {rem_reg, num_reg[WORD_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg      <= dividend[WORD_BITS-1:0];
            den_reg      <= divisor[WORD_BITS-1:0];
            den_zero_reg <= (divisor[WORD_BITS-1:0] == '0);
            rem_reg      <= '0;
            quo_reg      <= '0;
            cnt_reg      <= CNT_BITS'(WORD_BITS - 1);
        end
        else if (cmd.step)
        begin
            num_reg <= {num_reg[WORD_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_BITS'(1);
            if (!diff[WORD_BITS])
            begin
                rem_reg <= diff[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            quotient_reg <= den_zero_reg ? '0 : DATA_BITS'(quo_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.last_step = (cnt_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign quotient         = quotient_reg;

endmodule

@@ design/unsigned_divide_64_top.sv @@
// ----------------------------------------------------------------------------
// unsigned_divide_64_top
// 64-bit unsigned restoring divider returning the floor quotient (zero for a zero divisor).
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------
//   input    | in_valid, in_ready   | dividend, divisor
//   output   | out_valid, out_ready | quotient
//
// An item is handled in order: a load, one restoring compare-and-subtract
// step per quotient bit, and a publish into the output register. The single
// shared subtractor over WORD_BITS + 1 bits serves every step.
// Reset clears the sequencer and the output valid flag only.
// A result held in the output register does not block the next transfer in;
// a stalled output holds the finished item in the publish state.
// ----------------------------------------------------------------------------
module unsigned_divide_64_top #(
    parameter int WORD_BITS = udiv64_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [udiv64_pkg::DATA_BITS-1:0] dividend,
    input  logic [udiv64_pkg::DATA_BITS-1:0] divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [udiv64_pkg::DATA_BITS-1:0] quotient
);
    import udiv64_pkg::*;

    udiv64_cmd_t    cmd;
    udiv64_status_t status;

    udiv64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    udiv64_dpath #(
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dividend  (dividend),
        .divisor   (divisor),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quotient  (quotient)
    );

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a division is in flight");

    a_rise_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.publish))
        else $error("result appeared without a publish");

    a_publish_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> status.out_free)
        else $error("publish overwrote an untaken result");

endmodule

@@ tb/sv/unsigned_divide_64_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_divide_64_top_test
// Self-checking testbench for the 64-bit unsigned restoring divider. Operand
// pairs go in over the input handshake with random gaps, quotients come back
// under random output stalls, and each one is checked in order against a
// restoring-division predictor kept in the testbench.
// ----------------------------------------------------------------------------
module unsigned_divide_64_top_test;

    import udiv64_pkg::*;

    typedef logic [DATA_BITS-1:0] word_t;

    localparam int WB         = WORD_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    word_t dividend;
    word_t divisor;
    logic  out_valid;
    logic  out_ready;
    word_t quotient;

    word_t quotient_expected_q[$];
    int    error_count = 0;
    bit    tx_gap_en   = 1'b1;
    bit    rx_stall_en = 1'b1;

    unsigned_divide_64_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quotient  (quotient)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic word_t floor_quotient(word_t num_in, word_t den_in);
        logic [WB-1:0] num;
        logic [WB-1:0] den;
        logic [WB-1:0] quo;
        word_t         res;
        int            shifts;
        num    = num_in[WB-1:0];
        den    = den_in[WB-1:0];
        quo    = '0;
        res    = '0;
        shifts = 0;
        if (den == '0)
        begin
            return res;
        end
        while (!den[WB-1] && shifts < WB - 1)
        begin
            den = den << 1;
            shifts++;
        end
        for (int pos = 0; pos <= shifts; pos++)
        begin
            quo = quo << 1;
            if (num >= den)
            begin
                num    = num - den;
                quo[0] = 1'b1;
            end
            den = den >> 1;
        end
        res[WB-1:0] = quo;
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) < 16)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 80);
    endfunction

    function automatic word_t rand_word();
        word_t w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
        begin
            w = w >> $urandom_range(0, DATA_BITS - 1);
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // hold the transfer until accepted, then optionally drop valid for a gap
    task automatic send_operands(word_t num, word_t den);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        dividend <= num;
        divisor  <= den;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        quotient_expected_q.push_back(floor_quotient(num, den));
        gap = 0;
        if (tx_gap_en && $urandom_range(0, 2) == 0)
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (quotient_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed_corners();
        word_t ones;
        word_t top;
        ones = '1;
        top  = word_t'(1) << (WB - 1);
        send_operands('0, '0);
        send_operands('0, word_t'(1));
        send_operands(ones, ones);
        send_operands(ones, word_t'(1));
        send_operands(ones, '0);
        send_operands('0, ones);
        send_operands(word_t'(1), ones);
        send_operands(ones, word_t'(2));
        send_operands(top, word_t'(1));
        send_operands(top, top);
        send_operands(top - 1, top);
        send_operands(ones, top);
        send_operands(word_t'(100), word_t'(7));
        send_operands(word_t'(7), word_t'(100));
        send_operands(word_t'(64'h5555_5555_5555_5555), word_t'(64'haaaa_aaaa_aaaa_aaaa));
        send_operands(word_t'(64'haaaa_aaaa_aaaa_aaaa), word_t'(64'h5555_5555_5555_5555));
        send_operands(ones, word_t'(3));
        send_operands(word_t'(64'h0123_4567_89ab_cdef), word_t'(64'h0000_0001_0000_0000));
        wait_results_drained();
    endtask

    task automatic test_zero_divisor();
        for (int i = 0; i < 6; i++)
        begin
            send_operands(rand_word(), '0);
        end
        wait_results_drained();
    endtask

    task automatic test_random_operands();
        word_t num;
        word_t den;
        int    kind;
        for (int i = 0; i < 700; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_gap_en   = ($urandom_range(0, 3) != 0);
                rx_stall_en = ($urandom_range(0, 3) != 0);
            end
            if (i == 350)
            begin
                wait_results_drained();
            end
            kind = $urandom_range(0, 9);
            num  = {$urandom, $urandom};
            den  = rand_word();
            case (kind)
                0: den = '0;
                1: num = (den == '0) ? '0 : num % den;
                2: num = den;
                3: den = den | (word_t'(1) << (WB - 1));
                4: num = rand_word();
                default: ;
            endcase
            send_operands(num, den);
        end
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        for (int i = 0; i < 80; i++)
        begin
            send_operands({$urandom, $urandom}, rand_word());
        end
        wait_results_drained();
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (quotient_expected_q.size() == 0)
            begin
                report_mismatch("unexpected quotient", quotient, '0);
            end
            else if (quotient !== quotient_expected_q[0])
            begin
                report_mismatch("quotient", quotient, quotient_expected_q.pop_front());
            end
            else
            begin
                void'(quotient_expected_q.pop_front());
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("** unsigned_divide_64_top: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        dividend = '0;
        divisor  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_zero_divisor();
        test_random_operands();
        test_back_to_back();

        wait_results_drained();
        repeat (WB + 4) @(posedge clk);
        if (quotient_expected_q.size() != 0)
        begin
            report_mismatch("missing quotient", '0, quotient_expected_q[0]);
        end
        if (error_count == 0)
        begin
            $display("** unsigned_divide_64_top: PASSED **");
        end
        else
        begin
            $display("** unsigned_divide_64_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/udiv64_pkg.sv
design/udiv64_ctrl.sv
design/udiv64_dpath.sv
design/unsigned_divide_64_top.sv
tb/sv/unsigned_divide_64_top_test.sv
